// ----- rtl/egcd_pkg.sv -----
package egcd_pkg;

    localparam int FIELD_WIDTH = 32;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

endpackage

// ----- rtl/egcd_ctrl.sv -----
module egcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  egcd_pkg::t_status i_status,
    output egcd_pkg::t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step   = (r_state == S_RUN) && !i_status.done;
        o_cmd.finish = (r_state == S_RUN) && i_status.done && w_slot_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.finish) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("result dropped after finish");

    a_step_xor_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.step && o_cmd.finish))
        else $error("step and finish together");

    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !i_status.done) |=> (r_state == S_RUN))
        else $error("left run before done");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.finish)
        else $error("pending result overwritten");

endmodule

// ----- rtl/egcd_dp.sv -----
module egcd_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                             i_clk,
    input  egcd_pkg::t_cmd                   i_cmd,
    input  logic [egcd_pkg::FIELD_WIDTH-1:0] i_first,
    input  logic [egcd_pkg::FIELD_WIDTH-1:0] i_second,
    output egcd_pkg::t_status                o_status,
    output logic [egcd_pkg::FIELD_WIDTH-1:0] o_divisor
);

    localparam int KW = $clog2(DATA_WIDTH);
    localparam int EW = egcd_pkg::FIELD_WIDTH + DATA_WIDTH;

    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] n_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic [DATA_WIDTH-1:0] n_b;
    logic [KW-1:0]         r_k;
    logic [KW-1:0]         n_k;
    logic                  r_zero;
    logic                  n_zero;
    logic [egcd_pkg::FIELD_WIDTH-1:0] r_out;
    logic [egcd_pkg::FIELD_WIDTH-1:0] n_out;

    logic [EW-1:0]         w_first_ext;
    logic [EW-1:0]         w_second_ext;
    logic [DATA_WIDTH-1:0] w_opa;
    logic [DATA_WIDTH-1:0] w_opb;
    logic [DATA_WIDTH-1:0] w_res;
    logic [EW-1:0]         w_res_ext;
    logic [DATA_WIDTH-1:0] w_a_minus_b;
    logic [DATA_WIDTH-1:0] w_b_minus_a;

    assign w_first_ext  = {{DATA_WIDTH{1'b0}}, i_first};
    assign w_second_ext = {{DATA_WIDTH{1'b0}}, i_second};
    assign w_opa        = w_first_ext[DATA_WIDTH-1:0];
    assign w_opb        = w_second_ext[DATA_WIDTH-1:0];

    assign w_a_minus_b  = r_a - r_b;
    assign w_b_minus_a  = r_b - r_a;

    assign w_res        = r_zero ? '0 : (r_a << r_k);
    assign w_res_ext    = {{egcd_pkg::FIELD_WIDTH{1'b0}}, w_res};

    assign o_status.done = r_zero || (r_a == r_b);
    assign o_divisor     = r_out;

    // binary gcd step: strip common twos into k, odd pairs subtract and halve
    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_k    = r_k;
        n_zero = r_zero;
        n_out  = r_out;
        if (i_cmd.load) begin
            n_a    = w_opa;
            n_b    = w_opb;
            n_k    = '0;
            n_zero = (w_opa == '0) || (w_opb == '0);
        end else if (i_cmd.step) begin
            if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a > r_b) begin
                n_a = w_a_minus_b >> 1;
            end else begin
                n_b = w_b_minus_a >> 1;
            end
        end
        if (i_cmd.finish) begin
            n_out = w_res_ext[egcd_pkg::FIELD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_k    <= n_k;
        r_zero <= n_zero;
        r_out  <= n_out;
    end

endmodule

// ----- rtl/euclid_gcd_top.sv -----
// Operation: after an item is accepted, the datapath runs subtract/shift steps, one per cycle,
// until the operands are equal or one is zero, then registers the result once the output slot is free.
// Flow: one item at a time; the next item is taken the cycle after a result
// is registered, while that result may still wait at the output.
// Reset: i_rst_n synchronous, active low; clears controller state and output valid.
module euclid_gcd_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] first_value, [63:32] second_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] divisor
);

    egcd_pkg::t_cmd    w_cmd;
    egcd_pkg::t_status w_status;

    egcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    egcd_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_first   (i_s_axis_tdata[31:0]),
        .i_second  (i_s_axis_tdata[63:32]),
        .o_status  (w_status),
        .o_divisor (o_m_axis_tdata)
    );

endmodule

// ----- tb/tb_euclid_gcd_top.sv -----
module tb_euclid_gcd_top;

    localparam int FIELD_WIDTH  = egcd_pkg::FIELD_WIDTH;
    localparam int DATA_WIDTH   = 32;
    localparam int DRAIN_CYCLES = 2 * DATA_WIDTH + 8;
    localparam int RANDOM_ITEMS = 270;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] s_tdata;   // [31:0] first_value, [63:32] second_value
    logic        o_m_axis_tvalid;
    logic        m_tready;
    logic [31:0] o_m_axis_tdata;   // [31:0] divisor

    logic [FIELD_WIDTH-1:0] divisor_queue[$];
    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    euclid_gcd_top #(
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [FIELD_WIDTH-1:0] euclid_divisor(logic [DATA_WIDTH-1:0] a,
                                                             logic [DATA_WIDTH-1:0] b);
        logic [DATA_WIDTH-1:0] big;
        logic [DATA_WIDTH-1:0] lesser;
        logic [DATA_WIDTH-1:0] rem;
        if (a == 0 || b == 0) begin
            return '0;
        end
        big    = (a >= b) ? a : b;
        lesser = (a >= b) ? b : a;
        while (lesser != 0) begin
            rem    = big % lesser;
            big    = lesser;
            lesser = rem;
        end
        return FIELD_WIDTH'(big);
    endfunction

    function automatic longint unsigned fibonacci(int k);
        longint unsigned f0;
        longint unsigned f1;
        longint unsigned t;
        f0 = 0;
        f1 = 1;
        for (int i = 0; i < k; i++) begin
            t  = f0 + f1;
            f0 = f1;
            f1 = t;
        end
        return f0;
    endfunction

    // one process: pop on result, then queue the prediction for an accepted item
    always @(posedge i_clk) begin
        logic [FIELD_WIDTH-1:0] want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_tready) begin
                if (divisor_queue.size() == 0) begin
                    $error("unexpected result: divisor actual %0d", o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = divisor_queue.pop_front();
                    if (o_m_axis_tdata !== want) begin
                        $error("divisor mismatch: expected %0d actual %0d", want,
                               o_m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && o_s_axis_tready) begin
                divisor_queue.push_back(euclid_divisor(s_tdata[31:0], s_tdata[63:32]));
            end
        end
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic send_operands(input logic [31:0] first_value,
                                 input logic [31:0] second_value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {second_value, first_value};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic pick_operands(output logic [31:0] a, output logic [31:0] b);
        logic [31:0] g;
        logic [31:0] t;
        longint unsigned fa;
        longint unsigned fb;
        int k;
        case ($urandom_range(9))
            0: begin
                a = ($urandom_range(1)) ? 32'd0 : $urandom;
                b = ($urandom_range(1)) ? 32'd0 : $urandom >> $urandom_range(31);
                if (a != 0 && b != 0) a = 0;
            end
            1: begin
                a = $urandom >> $urandom_range(31);
                b = a;
            end
            2, 3: begin
                a = $urandom;
                b = $urandom;
            end
            4, 5: begin
                g = $urandom >> $urandom_range(8, 31);
                if (g == 0) g = 1;
                a = g * $urandom_range(32'hFFFF_FFFF / g);
                b = g * $urandom_range(32'hFFFF_FFFF / g);
            end
            6: begin
                // consecutive Fibonacci numbers need the most remainder steps
                k  = $urandom_range(2, 47);
                fa = fibonacci(k);
                fb = fibonacci(k - 1);
                g  = $urandom_range(32'(64'hFFFF_FFFF / fa));
                if (g == 0) g = 1;
                a = 32'(fa) * g;
                b = 32'(fb) * g;
            end
            7: begin
                a = $urandom_range(255);
                b = $urandom_range(255);
            end
            8: begin
                b = $urandom >> $urandom_range(31);
                if (b == 0) b = 1;
                a = b * $urandom_range(32'hFFFF_FFFF / b);
            end
            default: begin
                a = $urandom >> $urandom_range(31);
                b = $urandom >> $urandom_range(31);
            end
        endcase
        if ($urandom_range(1)) begin
            t = a;
            a = b;
            b = t;
        end
    endtask

    task automatic test_corner_operands();
        logic [31:0] pairs[$];
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        pairs = '{32'd0, 32'd0,
                  32'd0, 32'd5,
                  32'd7, 32'd0,
                  32'hFFFF_FFFF, 32'd0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'd1,
                  32'd1, 32'hFFFF_FFFF,
                  32'd1, 32'd1,
                  32'd12, 32'd18,
                  32'd18, 32'd12,
                  32'd1000, 32'd1000,
                  32'd2971215073, 32'd1836311903,
                  32'd1836311903, 32'd2971215073,
                  32'h8000_0000, 32'h4000_0000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFE,
                  32'h0003_0000, 32'h0005_0000,
                  32'd4294967291, 32'd4294967279,
                  32'hAAAA_AAAA, 32'h5555_5555,
                  32'h0000_0001, 32'h8000_0000,
                  32'd4294967295, 32'd65535};
        for (int i = 0; i < pairs.size(); i += 2) begin
            send_operands(pairs[i], pairs[i+1]);
        end
    endtask

    task automatic run_random_items(input int count);
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++) begin
            pick_operands(a, b);
            send_operands(a, b);
        end
    endtask

    task automatic test_random_slow_sink();
        sender_idle_pct   = 29;
        receiver_idle_pct = 60;
        run_random_items(RANDOM_ITEMS);
    endtask

    task automatic test_random_slow_source();
        sender_idle_pct   = 60;
        receiver_idle_pct = 29;
        run_random_items(RANDOM_ITEMS);
    endtask

    task automatic test_random_full_rate();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_items(RANDOM_ITEMS);
    endtask

    initial begin
        int waited;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_operands();
        test_random_slow_sink();
        test_random_slow_source();
        test_random_full_rate();
        s_tvalid <= 1'b0;

        waited = 0;
        while (divisor_queue.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (divisor_queue.size() != 0) begin
            $error("divisor: %0d results never arrived", divisor_queue.size());
        end

        if (mismatch_count == 0 && divisor_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
